### rtl/drx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drx_pkg
// shared types and constants of the delta-row encoder
// ----------------------------------------------------------------------------
package drx_pkg;

  // gap never grows past this, whatever the row length
  localparam int unsigned GAP_CAP = 3855;
  // offset field width, enough for GAP_CAP
  localparam int unsigned OFF_W   = 12;

  // offset values carried in the command byte itself stop here
  localparam logic [OFF_W-1:0] OFF_ESC  = OFF_W'(31);
  // value of one full extension byte
  localparam logic [OFF_W-1:0] EXT_FULL = OFF_W'(255);

  // one burst of results, handed from the delta stage to the emitter
  typedef struct packed {
    logic             p_en;     // first replacement goes out
    logic [OFF_W-1:0] p_off;    // its offset
    logic [2:0]       p_cnt_m1; // its byte count minus one
    logic [7:0][7:0]  p_data;   // its bytes, lowest index first
    logic             q_en;     // one-byte replacement at offset zero follows
    logic [7:0]       q_byte;   // its byte
    logic             st_en;    // end-of-row status closes the burst
    logic [15:0]      st_len;   // bytes written for the row
    logic             st_ovf;   // capacity was exceeded
  } drx_desc_t;

endpackage

### rtl/delta_row_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_row_encoder
// delta-row replacement encoder for one raster row against its seed row
// ----------------------------------------------------------------------------
// a position's first result beat passes the input, burst and output registers; one
//   that emits nothing leaves the input register even while the emitter is busy
// the emitter's byte-per-cycle walk (command, extension, data, status beats) sets
//   the rate of busy positions while the output does not stall
// reset clears row state and all valid flags; capacity returns to 65535
// ----------------------------------------------------------------------------
module delta_row_encoder #(
  parameter int unsigned ROW_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel: capacity in bytes per row
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // position beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // new_byte[7:0], seed_byte[15:8]
  input  logic [1:0]  s_axis_tuser,  // new_present[0], seed_present[1]
  input  logic        s_axis_tlast,  // row_end
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_byte[7:0], total_length[23:8], overflow[24]
  output logic        m_axis_tuser,  // kind: 0 stream byte, 1 row status
  output logic        m_axis_tlast   // burst_last
);
  import drx_pkg::*;

  logic        [15:0] cap_q;
  logic               desc_ready, desc_load;
  drx_desc_t          desc;

  // capacity register; the user is to write it between rows while nothing is in flight, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // per-position decisions: runs, gaps, capacity check, burst descriptor
  drx_delta #(
    .ROW_MAX (ROW_MAX)
  ) u_delta (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cap_i         (cap_q),
    .desc_ready_i  (desc_ready),
    .desc_load_o   (desc_load),
    .desc_o        (desc)
  );

  // burst walk: one result beat per cycle into the output register unless the output stalls
  drx_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (desc_load),
    .desc_i        (desc),
    .desc_ready_o  (desc_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/drx_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drx_delta
// input register, row state and per-position replacement decisions
// ----------------------------------------------------------------------------
module drx_delta #(
  parameter int unsigned ROW_MAX = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  input  logic              s_axis_tlast,
  input  logic [15:0]       cap_i,
  input  logic              desc_ready_i,
  output logic              desc_load_o,
  output drx_pkg::drx_desc_t desc_o
);
  import drx_pkg::*;

  localparam int unsigned GAP_LIMIT = (ROW_MAX - 1 < GAP_CAP) ? ROW_MAX - 1 : GAP_CAP;
  localparam int unsigned GW        = $clog2(GAP_LIMIT + 1);

  typedef enum logic [1:0] {
    REG_BOTH = 2'd0,
    REG_NEW  = 2'd1,
    REG_SEED = 2'd2,
    REG_NONE = 2'd3
  } region_e;

  // input register
  logic       in_valid_q;
  logic [7:0] in_new_q, in_seed_q;
  logic       in_np_q, in_sp_q, in_last_q;

  // row state
  logic [GW-1:0] gap_q, gap_d;
  logic [7:0]    rbuf_q [8];
  logic [2:0]    rlen_q, rlen_d;
  logic [GW-1:0] rgap_q;
  region_e       region_q, region_d;
  logic [15:0]   bw_q, bw_d;
  logic          ovf_q, ovf_d;

  logic          accept, take, has_res;
  logic [7:0]    a_byte, b_byte;
  region_e       reg_cur;
  logic          differ, run_act, flush1, flush2, flush3, gap_hit;
  logic [2:0]    rl_base;
  logic [GW-1:0] gap_base;
  logic          p_cand, q_cand, p_fit, q_fit;
  logic [7:0][7:0] buf_w, buf_old;
  logic [GW-1:0] p_off;
  logic [2:0]    p_cnt_m1;
  logic [15:0]   off16, x16, q255, len_p;
  logic          long_off;
  logic [16:0]   sum_p, sum_q;
  logic [15:0]   bw1, bw2;
  logic          ovf1, ovf2;

  assign a_byte  = in_np_q ? in_new_q  : 8'd0;
  assign b_byte  = in_sp_q ? in_seed_q : 8'd0;
  assign differ  = (a_byte != b_byte);
  assign run_act = (rlen_q != 3'd0);

  always_comb begin
    unique case ({in_np_q, in_sp_q})
      2'b11:   reg_cur = REG_BOTH;
      2'b10:   reg_cur = REG_NEW;
      2'b01:   reg_cur = REG_SEED;
      default: reg_cur = REG_NONE;
    endcase
  end

  // a pending run is cut by an unchanged byte or a region change
  assign flush1   = run_act && (!differ || reg_cur != region_q);
  assign rl_base  = flush1 ? 3'd0 : rlen_q;
  assign gap_base = flush1 ? '0 : gap_q;
  assign flush2   = differ && (rl_base == 3'd7);
  assign gap_hit  = !differ && (32'(gap_base) >= GAP_LIMIT);
  assign flush3   = in_last_q && differ && !flush2;
  assign p_cand   = flush1 || flush2 || gap_hit || flush3;
  assign q_cand   = flush1 && differ && in_last_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      buf_old[i] = rbuf_q[i];
      buf_w[i]   = (3'(i) == rl_base) ? a_byte : rbuf_q[i];
    end
  end

  assign p_off    = (flush1 || run_act) ? rgap_q : gap_q;
  assign p_cnt_m1 = flush1 ? (rlen_q - 3'd1) : (differ ? rl_base : 3'd0);

  // replacement length: command, extension bytes, data
  assign off16    = 16'(p_off);
  assign long_off = (off16 >= 16'd31);
  assign x16      = off16 - 16'd31;
  // divide by 255, exact over the whole offset range up to GAP_CAP
  assign q255     = (x16 + (x16 >> 8) + 16'd1) >> 8;
  assign len_p    = 16'd2 + 16'(p_cnt_m1) + (long_off ? q255 + 16'd1 : 16'd0);

  assign sum_p = {1'b0, bw_q} + {1'b0, len_p};
  assign p_fit = p_cand && !ovf_q && (sum_p <= {1'b0, cap_i});
  assign ovf1  = ovf_q | (p_cand & ~p_fit);
  assign bw1   = p_fit ? sum_p[15:0] : bw_q;

  assign sum_q = {1'b0, bw1} + 17'd2;
  assign q_fit = q_cand && !ovf1 && (sum_q <= {1'b0, cap_i});
  assign ovf2  = ovf1 | (q_cand & ~q_fit);
  assign bw2   = q_fit ? sum_q[15:0] : bw1;

  assign has_res = p_fit || q_fit || in_last_q;
  // positions without results pass even while the emitter is busy
  assign take          = in_valid_q && (desc_ready_i || !has_res);
  assign s_axis_tready = !in_valid_q || take;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign desc_load_o   = take && has_res;

  always_comb begin
    desc_o          = '0;
    desc_o.p_en     = p_fit;
    desc_o.p_off    = OFF_W'(p_off);
    desc_o.p_cnt_m1 = p_cnt_m1;
    desc_o.p_data   = flush1 ? buf_old : buf_w;
    desc_o.q_en     = q_fit;
    desc_o.q_byte   = a_byte;
    desc_o.st_en    = in_last_q;
    desc_o.st_len   = bw2;
    desc_o.st_ovf   = ovf2;
  end

  always_comb begin
    rlen_d   = (in_last_q || !differ || flush2) ? 3'd0 : rl_base + 3'd1;
    region_d = in_last_q ? REG_BOTH : reg_cur;
    bw_d     = in_last_q ? 16'd0 : bw2;
    ovf_d    = in_last_q ? 1'b0 : ovf2;
    if (in_last_q || flush2 || gap_hit) begin
      gap_d = '0;
    end else if (differ) begin
      gap_d = gap_base;
    end else begin
      gap_d = gap_base + GW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      gap_q      <= '0;
      rlen_q     <= 3'd0;
      rgap_q     <= '0;
      region_q   <= REG_BOTH;
      bw_q       <= 16'd0;
      ovf_q      <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (take) begin
        in_valid_q <= 1'b0;
      end
      if (take) begin
        gap_q    <= gap_d;
        rlen_q   <= rlen_d;
        region_q <= region_d;
        bw_q     <= bw_d;
        ovf_q    <= ovf_d;
        if (differ && rl_base == 3'd0) begin
          rgap_q <= gap_base;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_new_q  <= s_axis_tdata[7:0];
      in_seed_q <= s_axis_tdata[15:8];
      in_np_q   <= s_axis_tuser[0];
      in_sp_q   <= s_axis_tuser[1];
      in_last_q <= s_axis_tlast;
    end
    if (take && differ) begin
      rbuf_q[rl_base] <= a_byte;
    end
  end

endmodule

### rtl/drx_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drx_emit
// walks one burst and sends it a byte per beat through the output register
// ----------------------------------------------------------------------------
module drx_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  drx_pkg::drx_desc_t desc_i,
  output logic               desc_ready_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);
  import drx_pkg::*;

  typedef enum logic [5:0] {
    ST_CMD   = 6'b000001,
    ST_EXT   = 6'b000010,
    ST_DATA  = 6'b000100,
    ST_QCMD  = 6'b001000,
    ST_QDATA = 6'b010000,
    ST_STAT  = 6'b100000
  } phase_e;

  logic             dv_q;
  drx_desc_t        d_q;
  phase_e           ph_q, ph_d, ph_first, ph_after_p;
  logic [OFF_W-1:0] rem_q, rem_d;
  logic [2:0]       idx_q, idx_d;
  logic             adv, finish;

  logic        ov_q;
  logic [7:0]  ob_q, ob_d;
  logic        ok_q, ok_d;
  logic [15:0] ol_q, ol_d;
  logic        oo_q, oo_d;
  logic        olast_q;

  assign adv          = dv_q && (!ov_q || m_axis_tready);
  assign desc_ready_o = !dv_q || (adv && finish);

  always_comb begin
    if (desc_i.p_en) begin
      ph_first = ST_CMD;
    end else if (desc_i.q_en) begin
      ph_first = ST_QCMD;
    end else begin
      ph_first = ST_STAT;
    end
    ph_after_p = d_q.q_en ? ST_QCMD : ST_STAT;
  end

  always_comb begin
    ph_d   = ph_q;
    rem_d  = rem_q;
    idx_d  = idx_q;
    finish = 1'b0;
    ob_d   = 8'd0;
    ok_d   = 1'b0;
    ol_d   = 16'd0;
    oo_d   = 1'b0;
    unique case (ph_q)
      ST_CMD: begin
        ob_d  = {d_q.p_cnt_m1, (d_q.p_off >= OFF_ESC) ? 5'd31 : d_q.p_off[4:0]};
        idx_d = 3'd0;
        if (d_q.p_off >= OFF_ESC) begin
          ph_d  = ST_EXT;
          rem_d = d_q.p_off - OFF_ESC;
        end else begin
          ph_d = ST_DATA;
        end
      end
      ST_EXT: begin
        if (rem_q >= EXT_FULL) begin
          ob_d  = 8'd255;
          rem_d = rem_q - EXT_FULL;
        end else begin
          ob_d = rem_q[7:0];
          ph_d = ST_DATA;
        end
      end
      ST_DATA: begin
        ob_d = d_q.p_data[idx_q];
        if (idx_q == d_q.p_cnt_m1) begin
          ph_d   = ph_after_p;
          finish = !d_q.q_en && !d_q.st_en;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_QCMD: begin
        // count one at offset zero gives an all-zero command
        ob_d = 8'd0;
        ph_d = ST_QDATA;
      end
      ST_QDATA: begin
        ob_d   = d_q.q_byte;
        ph_d   = ST_STAT;
        finish = !d_q.st_en;
      end
      ST_STAT: begin
        ok_d   = 1'b1;
        ol_d   = d_q.st_len;
        oo_d   = d_q.st_ovf;
        finish = 1'b1;
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
      ph_q <= ST_STAT;
      ov_q <= 1'b0;
    end else begin
      if (load_i) begin
        dv_q <= 1'b1;
        ph_q <= ph_first;
      end else if (adv) begin
        dv_q <= !finish;
        ph_q <= ph_d;
      end
      if (adv) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      d_q <= desc_i;
    end
    if (adv) begin
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      ob_q    <= ob_d;
      ok_q    <= ok_d;
      ol_q    <= ol_d;
      oo_q    <= oo_d;
      olast_q <= finish;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, oo_q, ol_q, ob_q};
  assign m_axis_tuser  = ok_q;
  assign m_axis_tlast  = olast_q;

endmodule

### rtl/drx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drx_checker
// port-level checks of the delta-row encoder, bound to the top level
// ----------------------------------------------------------------------------
module drx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // the row status always closes its burst
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status beat without burst end");

  // stream bytes carry no length or overflow
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[24:8] == 17'd0)
    else $error("stream byte with status fields set");

  // status carries no stream byte
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status beat with nonzero byte");

endmodule

bind delta_row_encoder drx_checker u_drx_checker (.*);

### tb/sv/delta_row_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_row_encoder_tb
// self-checking bench for the delta-row replacement encoder: a row predictor
// runs beside the block, and every result beat is compared field by field with
// the oldest predicted beat. covers directed rows, capacity limits, offsets past
// the escape value, a long output hold-off, and random rows under three idling mixes
// ----------------------------------------------------------------------------
module delta_row_encoder_tb;
  import drx_pkg::*;

  localparam int unsigned ROW_MAX       = 4096;
  // offsets never grow past this; an unchanged position at the limit is resent
  localparam int unsigned GAP_LIMIT     = (ROW_MAX - 1 < GAP_CAP) ? ROW_MAX - 1 : GAP_CAP;
  localparam int unsigned RUN_MAX       = 8;
  localparam int unsigned CNT_SHIFT     = 5;
  localparam int unsigned ESC_OFF       = OFF_ESC;
  localparam int unsigned EXT_STEP      = EXT_FULL;
  localparam logic        KIND_BYTE     = 1'b0;
  localparam logic        KIND_STATUS   = 1'b1;
  localparam logic [15:0] CAP_MAX       = 16'hFFFF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {
    ZONE_BOTH,
    ZONE_NEW_ONLY,
    ZONE_SEED_ONLY,
    ZONE_NONE
  } zone_e;

  typedef struct packed {
    logic [7:0] new_byte;
    logic       new_present;
    logic [7:0] seed_byte;
    logic       seed_present;
    logic       row_end;
  } pos_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        kind;
    logic [15:0] total_length;
    logic        overflow;
    logic        burst_last;
  } beat_t;

  // dut signals; the driven inputs are known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // new_byte[7:0], seed_byte[15:8]
  logic [1:0]  s_axis_tuser  = '0;  // new_present[0], seed_present[1]
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // out_byte[7:0], total_length[23:8], overflow[24]
  logic        m_axis_tuser;        // kind
  logic        m_axis_tlast;        // burst_last

  // row predictor state
  logic [15:0] capacity_q   = CAP_MAX;
  int unsigned gap_cnt      = 0;
  int unsigned run_len      = 0;
  int unsigned run_off      = 0;
  int unsigned row_bytes    = 0;
  logic [7:0]  run_bytes [RUN_MAX];
  zone_e       zone_q       = ZONE_BOTH;
  bit          row_overflow = 1'b0;
  beat_t       burst [$];
  beat_t       expected_beats [$];

  // idling knobs and bookkeeping
  int unsigned send_gap_pct  = 12;
  int unsigned recv_gap_pct  = 45;
  int unsigned hold_off_left = 0;
  int unsigned mismatches    = 0;
  int unsigned positions_sent = 0;
  int unsigned rows_sent     = 0;
  int unsigned beats_checked = 0;
  int unsigned overflow_rows = 0;
  int unsigned cap_writes    = 0;

  delta_row_encoder #(
    .ROW_MAX(ROW_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // row predictor
  // ---------------------------------------------------------------------------

  function automatic void add_beat(logic [7:0] b, logic kind, logic [15:0] len, logic ovf);
    beat_t t;
    t.out_byte     = b;
    t.kind         = kind;
    t.total_length = len;
    t.overflow     = ovf;
    t.burst_last   = 1'b0;
    burst.push_back(t);
  endfunction

  // command byte, offset extension, then the run bytes; dropped whole if it
  // does not fit, which also silences the rest of the row
  function automatic void queue_replacement(int unsigned offset, logic [7:0] data [RUN_MAX],
                                            int unsigned count);
    int unsigned need;
    int unsigned rest;
    if (row_overflow || count == 0) return;
    need = 1 + count;
    if (offset >= ESC_OFF) need += (offset - ESC_OFF) / EXT_STEP + 1;
    if (row_bytes + need > capacity_q) begin
      row_overflow = 1'b1;
      return;
    end
    add_beat(8'(((count - 1) << CNT_SHIFT) + (offset < ESC_OFF ? offset : ESC_OFF)),
             KIND_BYTE, '0, 1'b0);
    if (offset >= ESC_OFF) begin
      rest = offset - ESC_OFF;
      while (rest >= EXT_STEP) begin
        add_beat(8'(EXT_STEP), KIND_BYTE, '0, 1'b0);
        rest -= EXT_STEP;
      end
      add_beat(8'(rest), KIND_BYTE, '0, 1'b0);
    end
    for (int i = 0; i < count; i++) add_beat(data[i], KIND_BYTE, '0, 1'b0);
    row_bytes += need;
  endfunction

  function automatic void flush_run();
    queue_replacement(run_off, run_bytes, run_len);
    run_len = 0;
    gap_cnt = 0;
  endfunction

  // works out the beats one accepted position causes
  function automatic void predict_position(pos_t p);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] same_byte [RUN_MAX];
    zone_e      zone_now;
    bit         differ;
    burst.delete();
    a        = p.new_present ? p.new_byte : 8'h00;
    b        = p.seed_present ? p.seed_byte : 8'h00;
    zone_now = p.new_present ? (p.seed_present ? ZONE_BOTH : ZONE_NEW_ONLY)
                             : (p.seed_present ? ZONE_SEED_ONLY : ZONE_NONE);
    differ   = (a != b);

    // an unchanged position or a zone change closes the open run
    if (run_len > 0 && (!differ || zone_now != zone_q)) flush_run();

    if (differ) begin
      if (run_len == 0) run_off = gap_cnt;
      run_bytes[run_len] = a;
      run_len++;
      if (run_len >= RUN_MAX) flush_run();
    end else if (gap_cnt >= GAP_LIMIT) begin
      // gap at its limit: resend this byte as a one-byte replacement
      same_byte[0] = a;
      queue_replacement(gap_cnt, same_byte, 1);
      gap_cnt = 0;
    end else begin
      gap_cnt++;
    end
    zone_q = zone_now;

    if (p.row_end) begin
      if (run_len > 0) flush_run();
      add_beat(8'h00, KIND_STATUS, 16'(row_bytes), row_overflow);
      if (row_overflow) overflow_rows++;
      rows_sent++;
      gap_cnt      = 0;
      run_len      = 0;
      run_off      = 0;
      zone_q       = ZONE_BOTH;
      row_bytes    = 0;
      row_overflow = 1'b0;
    end

    if (burst.size() > 0) burst[burst.size() - 1].burst_last = 1'b1;
    foreach (burst[i]) expected_beats.push_back(burst[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_beat();
    beat_t want;
    beats_checked++;
    if (expected_beats.size() == 0) begin
      flag_mismatch($sformatf("beat with nothing expected: tdata %h tuser %b tlast %b",
                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    want = expected_beats.pop_front();
    if (m_axis_tdata[7:0] != want.out_byte)
      flag_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata[7:0], want.out_byte));
    if (m_axis_tuser != want.kind)
      flag_mismatch($sformatf("kind %b, expected %b", m_axis_tuser, want.kind));
    if (m_axis_tdata[23:8] != want.total_length)
      flag_mismatch($sformatf("total_length %0d, expected %0d",
                              m_axis_tdata[23:8], want.total_length));
    if (m_axis_tdata[24] != want.overflow)
      flag_mismatch($sformatf("overflow %b, expected %b", m_axis_tdata[24], want.overflow));
    if (m_axis_tlast != want.burst_last)
      flag_mismatch($sformatf("burst_last %b, expected %b", m_axis_tlast, want.burst_last));
    if (m_axis_tdata[31:25] != '0)
      flag_mismatch($sformatf("tdata padding %h not zero", m_axis_tdata[31:25]));
  endtask

  // result side: check each beat, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_beat();
    m_axis_tready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_gap_pct);
  end

  // long receiver hold-off, counted down here once armed
  always @(posedge clk_i) begin
    if (hold_off_left != 0) hold_off_left <= hold_off_left - 1;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pos_t position(logic [7:0] nb, logic np, logic [7:0] sb, logic sp,
                                    logic last);
    pos_t p;
    p.new_byte     = nb;
    p.new_present  = np;
    p.seed_byte    = sb;
    p.seed_present = sp;
    p.row_end      = last;
    return p;
  endfunction

  // offers one position, idling first at random; valid stays high after the
  // beat so back-to-back positions never drop it
  task automatic send_pos(input pos_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {p.seed_byte, p.new_byte};
    s_axis_tuser  <= {p.seed_present, p.new_present};
    s_axis_tlast  <= p.row_end;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_position(p);
    positions_sent++;
  endtask

  // waits until every predicted beat has come, then lets the pipe settle
  task automatic drain(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    drain(SETTLE_CYCLES);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_q = cap;
    cap_writes++;
  endtask

  // well-formed row: both rows present up to their lengths, changes in clusters
  task automatic send_random_row();
    int unsigned new_len;
    int unsigned seed_len;
    int unsigned span;
    bit          in_change;
    pos_t        p;
    new_len   = ($urandom_range(19) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 30);
    seed_len  = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : new_len;
    span      = (new_len > seed_len) ? new_len : seed_len;
    if ($urandom_range(4) == 0) span += $urandom_range(1, 4);
    if (span == 0) span = 1;
    in_change = 1'($urandom_range(1));
    for (int i = 0; i < span; i++) begin
      if ($urandom_range(99) < 25) in_change = !in_change;
      p.seed_byte    = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
      p.new_byte     = in_change ? (($urandom_range(9) == 0) ? 8'h00 : 8'($urandom))
                                 : p.seed_byte;
      p.new_present  = (i < new_len);
      p.seed_present = (i < seed_len);
      p.row_end      = (i == span - 1);
      send_pos(p);
    end
  endtask

  // noise row: every field random, ended explicitly
  task automatic send_noise_row();
    int unsigned span;
    pos_t        p;
    span = $urandom_range(1, 20);
    for (int i = 0; i < span; i++) begin
      p         = pos_t'($urandom);
      p.row_end = (i == span - 1) || ($urandom_range(15) == 0);
      send_pos(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // every zone in one row, a run cut by a zone change, absent bytes as zero
    send_pos(position(8'h00, 1'b1, 8'h00, 1'b1, 1'b0));
    send_pos(position(8'hFF, 1'b1, 8'h00, 1'b1, 1'b0));
    send_pos(position(8'h00, 1'b1, 8'hFF, 1'b1, 1'b0));
    send_pos(position(8'h80, 1'b1, 8'h7F, 1'b1, 1'b0));
    send_pos(position(8'h12, 1'b1, 8'hC3, 1'b0, 1'b0));  // zone change inside a run
    send_pos(position(8'h00, 1'b1, 8'hFF, 1'b0, 1'b0));  // absent seed equals zero
    send_pos(position(8'h55, 1'b0, 8'h00, 1'b1, 1'b0));  // both read as zero
    send_pos(position(8'hFF, 1'b0, 8'hA5, 1'b1, 1'b0));  // absent new byte sent as zero
    send_pos(position(8'hFF, 1'b0, 8'hFF, 1'b0, 1'b1));  // neither present, row end
    // nine changes: a full run of eight, the ninth flushed by the row end
    for (int i = 0; i < 9; i++) send_pos(position(8'(i + 1), 1'b1, 8'hFF, 1'b1, i == 8));
    // one-position rows
    send_pos(position(8'h01, 1'b1, 8'h02, 1'b1, 1'b1));
    send_pos(position(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1));
    send_pos(position(8'h3C, 1'b0, 8'hC3, 1'b0, 1'b1));
  endtask

  task automatic test_capacity();
    send_gap_pct = 45;
    recv_gap_pct = 12;
    // zero capacity: an unchanged row still reports length 0, a change overflows
    write_capacity(16'd0);
    for (int i = 0; i < 3; i++) send_pos(position(8'hAA, 1'b1, 8'hAA, 1'b1, i == 2));
    send_pos(position(8'h01, 1'b1, 8'h00, 1'b1, 1'b0));
    send_pos(position(8'h00, 1'b1, 8'h00, 1'b1, 1'b1));
    // exact fit: one two-byte replacement takes three bytes
    write_capacity(16'd3);
    send_pos(position(8'h10, 1'b1, 8'h00, 1'b1, 1'b0));
    send_pos(position(8'h20, 1'b1, 8'h00, 1'b1, 1'b0));
    send_pos(position(8'h00, 1'b1, 8'h00, 1'b1, 1'b1));
    // second replacement does not fit; the third must stay silent too
    write_capacity(16'd4);
    for (int i = 0; i < 9; i++)
      send_pos(position((i % 3 == 2) ? 8'h00 : 8'(8'h40 + i), 1'b1, 8'h00, 1'b1, i == 8));
    write_capacity(CAP_MAX);
  endtask

  task automatic test_long_gaps();
    int unsigned gap_list [3] = '{30, 31, 32};
    logic [7:0]  b;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    // offsets just below, at and past the escape value
    foreach (gap_list[g]) begin
      for (int i = 0; i < gap_list[g]; i++) begin
        b = 8'($urandom);
        send_pos(position(b, 1'b1, b, 1'b1, 1'b0));
      end
      send_pos(position(8'h5A, 1'b1, 8'hA5, 1'b1, 1'b0));
      send_pos(position(8'h77, 1'b1, 8'h00, 1'b1, 1'b0));
      send_pos(position(8'h00, 1'b1, 8'h00, 1'b1, 1'b1));
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    drain(SETTLE_CYCLES);
    // receiver holds off while the sender keeps offering changes
    hold_off_left <= HOLD_CYCLES;
    for (int i = 0; i < 32; i++)
      send_pos(position(8'($urandom_range(1, 255)), 1'b1, 8'h00, 1'b1, i == 31));
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_random();
    int unsigned send_pct [3] = '{12, 45, 0};
    int unsigned recv_pct [3] = '{45, 12, 0};
    int unsigned start;
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = send_pct[phase];
      recv_gap_pct = recv_pct[phase];
      for (int batch = 0; batch < 3; batch++) begin
        case (batch)
          0: write_capacity(16'($urandom_range(0, 40)));
          1: write_capacity(16'($urandom_range(0, 65535)));
          default: write_capacity(CAP_MAX);
        endcase
        start = positions_sent;
        while (positions_sent - start < 14) begin
          if ($urandom_range(9) == 0) send_noise_row();
          else send_random_row();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_long_gaps();
    test_backpressure();
    test_random();

    drain(SETTLE_CYCLES);
    if (expected_beats.size() != 0)
      flag_mismatch($sformatf("%0d predicted beats never arrived", expected_beats.size()));

    $display("run covered %0d positions in %0d rows, %0d result beats, %0d rows overflowed",
             positions_sent, rows_sent, beats_checked, overflow_rows);
    $display("capacity written %0d times; mismatches %0d", cap_writes, mismatches);
    if (mismatches == 0) begin
      $display("delta_row_encoder_tb: clean");
    end else begin
      $display("delta_row_encoder_tb: errors");
    end
    $finish;
  end

  // watchdog: well beyond the slowest correct run
  initial begin
    #400_000;
    $display("watchdog expired with %0d beats outstanding", expected_beats.size());
    $display("delta_row_encoder_tb: errors");
    $finish;
  end

endmodule
